FILE: rtl/emp_pkg.sv
// ----------------------------------------------------------------------------
// emp_pkg
// Shared types and constants for the multi-turn encoder position block.
// ----------------------------------------------------------------------------
`default_nettype none

package emp_pkg;

  localparam int ACC_W       = 32;    // multi-turn accumulator width
  localparam int CPR_W       = 16;    // counts_per_rev register width
  localparam int POS_W       = 16;    // position result width
  localparam int QUEUE_DEPTH = 4;     // front to back queue entries
  localparam int QUEUE_AW    = 2;     // queue pointer bits

  localparam logic [CPR_W-1:0] CPR_RESET = 16'd9362;

  localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7fff;
  localparam logic signed [POS_W-1:0] POS_MIN = 16'sh8000;

  // step classification done by the front end
  typedef enum logic [1:0] {
    WRAP_NONE,
    WRAP_UP,
    WRAP_DOWN
  } wrap_t;

  // one beat written into the queue
  typedef struct packed {
    logic                    push;
    logic signed [ACC_W-1:0] acc;
  } acc_push_t;

  // queue status toward both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/emp_front.sv
// ----------------------------------------------------------------------------
// emp_front
// Accepts angle samples, classifies the step as wrap or not and updates the
// saturating multi-turn accumulator; each new value goes into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module emp_front
  import emp_pkg::*;
#(
  parameter int ANGLE_BITS = 21
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic [ANGLE_BITS-1:0] angle,
  input  wire q_stat_t               q_stat,
  output acc_push_t                  q_wr
);

  localparam int N  = ANGLE_BITS;
  localparam int SW = ACC_W + 2;

  localparam logic signed [N:0]    HALF = (N+1)'((1 << (N-1)) - 1);
  localparam logic signed [SW-1:0] TURN = SW'(1) << N;

  logic [N-1:0]            last_angle;
  logic signed [ACC_W-1:0] turn_acc;
  logic signed [ACC_W-1:0] turn_acc_next;
  logic signed [N:0]       step;
  logic signed [SW-1:0]    step_ext;
  logic signed [SW-1:0]    acc_ext;
  logic signed [SW-1:0]    corr;
  logic signed [SW-1:0]    sum;
  wrap_t                   wrap;
  logic                    accept;

  assign accept = push && !q_stat.full;

  assign step     = $signed({1'b0, angle}) - $signed({1'b0, last_angle});
  assign step_ext = {{(SW-N-1){step[N]}}, step};
  assign acc_ext  = {{(SW-ACC_W){turn_acc[ACC_W-1]}}, turn_acc};

  always_comb begin
    priority if (step > HALF) begin
      wrap = WRAP_UP;
    end else if (step < -HALF) begin
      wrap = WRAP_DOWN;
    end else begin
      wrap = WRAP_NONE;
    end
  end

  always_comb begin
    unique case (wrap)
      WRAP_UP:   corr = TURN;
      WRAP_DOWN: corr = -TURN;
      default:   corr = '0;
    endcase
  end

  // direction is reversed: the step is subtracted
  assign sum = acc_ext + corr - step_ext;

  always_comb begin
    if (sum[SW-1:ACC_W-1] == '0 || sum[SW-1:ACC_W-1] == '1) begin
      turn_acc_next = sum[ACC_W-1:0];
    end else if (sum[SW-1]) begin
      turn_acc_next = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      turn_acc_next = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle <= '0;
      turn_acc   <= '0;
    end else if (accept) begin
      last_angle <= angle;
      turn_acc   <= turn_acc_next;
    end
  end

  assign q_wr.push = accept;
  assign q_wr.acc  = turn_acc_next;

endmodule

`default_nettype wire

FILE: rtl/emp_queue.sv
// ----------------------------------------------------------------------------
// emp_queue
// Short queue of accumulator values between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module emp_queue
  import emp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire acc_push_t               q_wr,
  input  wire logic                    q_pop,
  output q_stat_t                      q_stat,
  output logic signed [ACC_W-1:0]      head
);

  logic signed [ACC_W-1:0] entry [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr;
  logic [QUEUE_AW-1:0]     rd_ptr;
  logic [QUEUE_AW:0]       count;
  logic                    do_push;
  logic                    do_pop;

  assign q_stat.full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

  assign do_push = q_wr.push && !q_stat.full;
  assign do_pop  = q_pop && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= q_wr.acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head = entry[rd_ptr];

endmodule

`default_nettype wire

FILE: rtl/emp_back.sv
// ----------------------------------------------------------------------------
// emp_back
// Scales the accumulator by counts_per_rev, divides by the full-scale angle
// with truncation toward zero and saturates to 16 bits. Four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module emp_back
  import emp_pkg::*;
#(
  parameter int ANGLE_BITS = 21
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire q_stat_t                 q_stat,
  input  wire logic signed [ACC_W-1:0] head,
  output logic                         q_pop,
  input  wire logic [CPR_W-1:0]        cpr,
  input  wire logic                    pop,
  output logic                         empty,
  output logic signed [POS_W-1:0]      position
);

  localparam int N   = ANGLE_BITS;
  localparam int PW  = ACC_W + CPR_W + 1;
  localparam int MW  = PW - 1;
  localparam int CW  = ((N > POS_W) ? N : POS_W) + 1;
  localparam int QW  = POS_W + 2;

  localparam logic [N:0]    DIV     = {1'b0, {N{1'b1}}};
  localparam logic [QW-1:0] LIM_POS = QW'((1 << (POS_W-1)) - 1);
  localparam logic [QW-1:0] LIM_NEG = QW'(1 << (POS_W-1));

  logic                 v1, v2, v3, v4;
  logic                 advance;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_abs;
  logic                 neg2, neg3;
  logic [MW-1:0]        mag;
  logic                 a_big;
  logic [POS_W-1:0]     a_lo;
  logic [CW-1:0]        c;
  logic [CW-N-1:0]      c1;
  logic [N:0]           c2;
  logic [N:0]           r;
  logic                 inc;
  logic [QW-1:0]        q;
  logic [QW-1:0]        q_neg;
  logic signed [POS_W-1:0] pos_next;

  // whole pipe moves together while the result slot can take a beat
  assign advance = !v4 || pop;
  assign q_pop   = advance && !q_stat.empty;

  assign prod_abs = prod[PW-1] ? -prod : prod;

  // mag = a*2^N + b = a*D + (a + b); folded twice, then one correction
  assign c1  = c[CW-1:N];
  assign c2  = (N+1)'(c1) + (N+1)'(c[N-1:0]);
  assign r   = (N+1)'(c2[N]) + (N+1)'(c2[N-1:0]);
  assign inc = (r >= DIV);
  assign q   = QW'(a_lo) + QW'(c1) + QW'(c2[N]) + QW'(inc);
  assign q_neg = -q;

  always_comb begin
    priority if (!neg3 && (a_big || q > LIM_POS)) begin
      pos_next = POS_MAX;
    end else if (neg3 && (a_big || q > LIM_NEG)) begin
      pos_next = POS_MIN;
    end else if (neg3) begin
      pos_next = q_neg[POS_W-1:0];
    end else begin
      pos_next = q[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= !q_stat.empty;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod     <= head * $signed({1'b0, cpr});
      neg2     <= prod[PW-1];
      mag      <= prod_abs[MW-1:0];
      neg3     <= neg2;
      a_big    <= |mag[MW-1:N+POS_W];
      a_lo     <= mag[N+POS_W-1:N];
      c        <= CW'(mag[N+POS_W-1:N]) + CW'(mag[N-1:0]);
      position <= pos_next;
    end
  end

  assign empty = !v4;

endmodule

`default_nettype wire

FILE: rtl/encoder_multiturn_position.sv
// ----------------------------------------------------------------------------
// encoder_multiturn_position
// Unwraps absolute single-turn angle samples into a reversed, saturating
// multi-turn count and reports it scaled to a 16-bit position.
// ----------------------------------------------------------------------------
//
//   channel   ports                          beat moves when
//   input     push, full, angle              push && !full
//   result    empty, pop, position           pop && !empty
//   config    cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// one sample accepted per cycle while full is low; the accumulator recurrence
// is a single add; each result passes the queue, then the product,
// magnitude, fold and position registers; a stalled result holds the pipe;
// a four-entry queue keeps taking samples until it fills, then full rises
// reset is synchronous and clears the angle, the accumulator, the queue and
// the pipe; counts_per_rev returns to 9362
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_multiturn_position
  import emp_pkg::*;
#(
  parameter int ANGLE_BITS = 21
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [ANGLE_BITS-1:0] angle,
  output logic                       empty,
  input  wire logic                  pop,
  output logic signed [POS_W-1:0]    position,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CPR_W-1:0]      cfg_data
);

  acc_push_t               q_wr;
  q_stat_t                 q_stat;
  logic                    q_pop;
  logic signed [ACC_W-1:0] head;
  logic [CPR_W-1:0]        cpr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpr <= CPR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cpr <= cfg_data;
    end
  end

  emp_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .angle  (angle),
    .q_stat (q_stat),
    .q_wr   (q_wr)
  );

  emp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_pop  (q_pop),
    .q_stat (q_stat),
    .head   (head)
  );

  emp_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .head     (head),
    .q_pop    (q_pop),
    .cpr      (cpr),
    .pop      (pop),
    .empty    (empty),
    .position (position)
  );

  assign full = q_stat.full;

endmodule

`default_nettype wire

FILE: rtl/emp_checker.sv
// ----------------------------------------------------------------------------
// emp_checker
// Port-level checks on the multi-turn position block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module emp_checker
  import emp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  full,
  input wire logic                  empty,
  input wire logic                  pop,
  input wire logic [POS_W-1:0]      position
);

  // reset leaves nothing waiting and room for samples
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue or result not cleared by reset");

  // the queue can only fill while a result is held back
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(!empty && !pop))
    else $error("full rose without a stalled result");

  a_full_stalled: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("full while no result is waiting");

  // a waiting result that is not taken stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(position))
    else $error("waiting result changed before it was taken");

endmodule

bind encoder_multiturn_position emp_checker u_emp_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .position  (position)
);

`default_nettype wire
